>>> hdl/lrt_pkg.sv
// Shared types and constants for the LRU table with pinning.
// Used by lrt_ctrl, lrt_dpath and lru_table_with_pinning.
`default_nettype none
package lrt_pkg;

  localparam int ENTRIES_DEF     = 64;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int STAMP_BITS      = 64;
  localparam int CAP_BITS        = 7;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_GET    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_SETUSE = 3'd5,
    CMD_TRIM   = 3'd6,
    CMD_NOP    = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [63:0] key;
    logic [31:0] handle;
    logic        in_use;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] found_handle;
    logic [6:0]  entry_count;
    logic [6:0]  evicted_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic act;
    logic evict;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic over_cap;
    logic vict_found;
  } ctl_sts_t;

endpackage
`default_nettype wire

>>> hdl/lrt_ctrl.sv
// Sequencing state machine: lookup scan, action, eviction scans, response.
// Depends on lrt_pkg.
`default_nettype none
module lrt_ctrl import lrt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output ctl_cmd_t      cmd,
  input  wire ctl_sts_t sts
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_ACT   = 7'b0000100,
    ST_CHECK = 7'b0001000,
    ST_ESCAN = 7'b0010000,
    ST_EVICT = 7'b0100000,
    ST_RESP  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) state_next = ST_ACT;
      end
      ST_ACT: begin
        cmd.act    = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.over_cap) begin
          cmd.scan_start = 1'b1;
          state_next     = ST_ESCAN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_ESCAN: begin
        if (sts.scan_done) state_next = ST_EVICT;
      end
      ST_EVICT: begin
        cmd.evict  = 1'b1;
        state_next = sts.vict_found ? ST_CHECK : ST_RESP;
      end
      ST_RESP: begin
        if (rsp_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/lrt_dpath.sv
// Datapath: entry memory, valid bits, scan trackers, counters, result register.
// Depends on lrt_pkg.
`default_nettype none
module lrt_dpath import lrt_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire req_t                req,
  input  wire logic                cfg_valid,
  input  wire logic [CAP_BITS-1:0] cfg_data,
  input  wire ctl_cmd_t            cmd,
  output ctl_sts_t                 sts,
  output rsp_t                     rsp
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int XW = (CW > CAP_BITS) ? CW : CAP_BITS;
  localparam int KO = 0;
  localparam int HO = KEY_BITS;
  localparam int SO = KEY_BITS + HANDLE_BITS;
  localparam int PO = SO + STAMP_BITS;
  localparam int W  = PO + 1;

  logic [W-1:0]           mem [ENTRIES];
  logic [W-1:0]           rdata;
  logic [ENTRIES-1:0]     valid;
  logic [CW-1:0]          count;
  logic [CW-1:0]          ev_cnt;
  logic [STAMP_BITS-1:0]  ctr;
  logic [CAP_BITS-1:0]    capacity;

  cmd_e                   c_cmd;
  logic [KEY_BITS-1:0]    c_key;
  logic [HANDLE_BITS-1:0] c_h;
  logic                   c_pin;

  logic [CW-1:0]          cnt;
  logic                   scanning;
  logic                   pend;
  logic [IW-1:0]          pend_idx;

  logic                   hit;
  logic [IW-1:0]          hit_idx;
  logic [HANDLE_BITS-1:0] hit_h;
  logic [STAMP_BITS-1:0]  hit_stamp;
  logic                   hit_pin;
  logic                   free_found;
  logic [IW-1:0]          free_idx;
  logic                   vict_found;
  logic [IW-1:0]          vict_idx;
  logic [STAMP_BITS-1:0]  vict_stamp;

  logic                   ok;
  logic [HANDLE_BITS-1:0] fh;
  logic                   evict_en;

  logic                   we;
  logic [IW-1:0]          wa;
  logic [W-1:0]           wd;

  logic                   p_v;
  logic [KEY_BITS-1:0]    p_key;
  logic [HANDLE_BITS-1:0] p_h;
  logic [STAMP_BITS-1:0]  p_stamp;
  logic                   p_pin;
  logic [CAP_BITS-1:0]    cap_eff;
  logic                   put_bad;

  assign p_v     = valid[pend_idx];
  assign p_key   = rdata[KO +: KEY_BITS];
  assign p_h     = rdata[HO +: HANDLE_BITS];
  assign p_stamp = rdata[SO +: STAMP_BITS];
  assign p_pin   = rdata[PO];
  assign cap_eff = (capacity == '0) ? CAP_BITS'(1) : capacity;
  assign put_bad = (c_key == '0) || (c_h == '0);

  assign sts.scan_done  = scanning && (cnt == CW'(ENTRIES)) && !pend;
  assign sts.over_cap   = evict_en && (XW'(count) > XW'(cap_eff));
  assign sts.vict_found = vict_found;

  assign rsp.ok            = ok;
  assign rsp.found_handle  = 32'(fh);
  assign rsp.entry_count   = 7'(count);
  assign rsp.evicted_count = 7'(ev_cnt);

  // memory write port, active only in the action cycle
  always_comb begin
    we = 1'b0;
    wa = hit_idx;
    wd = {c_pin, ctr + STAMP_BITS'(1), c_h, c_key};
    if (cmd.act) begin
      case (c_cmd)
        CMD_PUT: begin
          if (!put_bad) begin
            if (hit) begin
              we = 1'b1;
            end else if (free_found) begin
              we = 1'b1;
              wa = free_idx;
            end else if (vict_found) begin
              we = 1'b1;
              wa = vict_idx;
            end
          end
        end
        CMD_GET: begin
          we = hit;
          wd = {hit_pin, ctr + STAMP_BITS'(1), hit_h, c_key};
        end
        CMD_SETUSE: begin
          we = hit;
          wd = {c_pin, hit_stamp, hit_h, c_key};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[cnt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd <= req.command;
      c_key <= KEY_BITS'(req.key);
      c_h   <= HANDLE_BITS'(req.handle);
      c_pin <= req.in_use;
    end
    if (cmd.scan_start) begin
      hit_idx  <= '0;
      free_idx <= '0;
      vict_idx <= '0;
    end else if (pend && p_v) begin
      if (p_key == c_key) begin
        hit_idx   <= pend_idx;
        hit_h     <= p_h;
        hit_stamp <= p_stamp;
        hit_pin   <= p_pin;
      end
      if (!p_pin && (!vict_found || p_stamp < vict_stamp)) begin
        vict_idx   <= pend_idx;
        vict_stamp <= p_stamp;
      end
    end else if (pend && !free_found) begin
      free_idx <= pend_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      count      <= '0;
      ctr        <= '0;
      capacity   <= CAP_RESET;
      scanning   <= 1'b0;
      pend       <= 1'b0;
      pend_idx   <= '0;
      cnt        <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      vict_found <= 1'b0;
      ok         <= 1'b0;
      fh         <= '0;
      ev_cnt     <= '0;
      evict_en   <= 1'b0;
    end else begin
      if (cfg_valid) capacity <= cfg_data;

      if (cmd.load) begin
        ok       <= 1'b0;
        fh       <= '0;
        ev_cnt   <= '0;
        evict_en <= 1'b0;
      end

      // scan pipeline: read at cnt, evaluate in the following cycle
      if (cmd.scan_start) begin
        scanning   <= 1'b1;
        cnt        <= '0;
        pend       <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        vict_found <= 1'b0;
      end else if (scanning) begin
        if (cnt != CW'(ENTRIES)) begin
          pend     <= 1'b1;
          pend_idx <= cnt[IW-1:0];
          cnt      <= cnt + CW'(1);
        end else begin
          pend <= 1'b0;
          if (!pend) scanning <= 1'b0;
        end
        if (pend && p_v) begin
          if (p_key == c_key) hit <= 1'b1;
          if (!p_pin) vict_found <= 1'b1;
        end else if (pend) begin
          free_found <= 1'b1;
        end
      end

      if (cmd.act) begin
        case (c_cmd)
          CMD_PUT: begin
            if (!put_bad) begin
              if (hit) begin
                ctr      <= ctr + STAMP_BITS'(1);
                ok       <= 1'b1;
                evict_en <= 1'b1;
              end else if (free_found) begin
                ctr             <= ctr + STAMP_BITS'(1);
                ok              <= 1'b1;
                evict_en        <= 1'b1;
                valid[free_idx] <= 1'b1;
                count           <= count + CW'(1);
              end else if (vict_found) begin
                ctr      <= ctr + STAMP_BITS'(1);
                ok       <= 1'b1;
                evict_en <= 1'b1;
                ev_cnt   <= CW'(1);
              end else if (!c_pin) begin
                ctr    <= ctr + STAMP_BITS'(1);
                ok     <= 1'b1;
                ev_cnt <= CW'(1);
              end
            end
          end
          CMD_GET: begin
            if (hit) begin
              ok  <= 1'b1;
              fh  <= hit_h;
              ctr <= ctr + STAMP_BITS'(1);
            end
          end
          CMD_PEEK: begin
            if (hit) begin
              ok <= 1'b1;
              fh <= hit_h;
            end
          end
          CMD_ERASE: begin
            if (hit) begin
              ok             <= 1'b1;
              valid[hit_idx] <= 1'b0;
              count          <= count - CW'(1);
            end
          end
          CMD_CLEAR: begin
            valid <= '0;
            count <= '0;
          end
          CMD_SETUSE: begin
            if (hit) ok <= 1'b1;
          end
          CMD_TRIM: evict_en <= 1'b1;
          default: ok <= 1'b0;
        endcase
      end

      if (cmd.evict && vict_found) begin
        valid[vict_idx] <= 1'b0;
        count           <= count - CW'(1);
        ev_cnt          <= ev_cnt + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/lru_table_with_pinning.sv
// A request runs a lookup scan over all entries, an action step, a capacity check
// and a response; each eviction adds an eviction scan, and a final scan that finds
// only pinned entries ends the sequence. One transaction is processed at a time;
// the per-entry memory scan sets the rate.
// Reset clears valid bits, counts, access counter and capacity (64); entry
// contents are not cleared, so no clearing pass follows reset.
`default_nettype none
module lru_table_with_pinning import lrt_pkg::*; #(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire req_t                req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output rsp_t                     rsp,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CAP_BITS-1:0] cfg_data
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  lrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  lrt_dpath #(
    .ENTRIES     (ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for lru_table_with_pinning: directed table, then random
// command mix, checked against an in-bench LRU/pinning predictor.
// Depends on lrt_pkg and the lru_table_with_pinning RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import lrt_pkg::*;

  localparam int NSLOT = 64;
  localparam int NRAND = 1600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CAP_BITS-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  lru_table_with_pinning dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  bit          t_valid [NSLOT];
  logic [63:0] t_key [NSLOT];
  logic [31:0] t_handle [NSLOT];
  logic [63:0] t_stamp [NSLOT];
  bit          t_pin [NSLOT];
  logic [63:0] t_clock;
  int          t_count;
  int          t_cap;

  rsp_t expected_q[$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  logic [63:0] keys_seen[$];

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < NSLOT; i++) if (t_valid[i] && t_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int oldest_unpinned();
    int v;
    v = -1;
    for (int i = 0; i < NSLOT; i++)
      if (t_valid[i] && !t_pin[i] && (v < 0 || t_stamp[i] < t_stamp[v])) v = i;
    return v;
  endfunction

  function automatic int shrink_to_cap();
    int cap, n, v;
    cap = (t_cap == 0) ? 1 : t_cap;
    n = 0;
    while (t_count > cap) begin
      v = oldest_unpinned();
      if (v < 0) break;
      t_valid[v] = 0;
      t_count--;
      n++;
    end
    return n;
  endfunction

  function automatic rsp_t predict_lru(req_t r);
    rsp_t o;
    int s, v, ev;
    o = '0;
    ev = 0;
    case (r.command)
      CMD_PUT: begin
        if (r.key != 0 && r.handle != 0) begin
          s = slot_of(r.key);
          if (s < 0) begin
            for (int i = 0; i < NSLOT && s < 0; i++) if (!t_valid[i]) s = i;
            if (s < 0) begin
              v = oldest_unpinned();
              if (v >= 0) begin
                t_valid[v] = 0;
                t_count--;
                ev++;
                s = v;
              end else if (!r.in_use) begin
                t_clock++;
                o.ok = 1;
                ev = 1;
              end
            end
            if (s >= 0) begin
              t_valid[s] = 1;
              t_count++;
            end
          end
          if (s >= 0) begin
            t_clock++;
            t_key[s] = r.key;
            t_handle[s] = r.handle;
            t_stamp[s] = t_clock;
            t_pin[s] = r.in_use;
            o.ok = 1;
            ev += shrink_to_cap();
          end
        end
      end
      CMD_GET, CMD_PEEK: begin
        s = slot_of(r.key);
        if (s >= 0) begin
          o.ok = 1;
          o.found_handle = t_handle[s];
          if (r.command == CMD_GET) begin
            t_clock++;
            t_stamp[s] = t_clock;
          end
        end
      end
      CMD_ERASE: begin
        s = slot_of(r.key);
        if (s >= 0) begin
          t_valid[s] = 0;
          t_count--;
          o.ok = 1;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) t_valid[i] = 0;
        t_count = 0;
      end
      CMD_SETUSE: begin
        s = slot_of(r.key);
        if (s >= 0) begin
          t_pin[s] = r.in_use;
          o.ok = 1;
        end
      end
      CMD_TRIM: ev = shrink_to_cap();
      default: ;
    endcase
    o.entry_count = t_count[6:0];
    o.evicted_count = ev[6:0];
    return o;
  endfunction

  // response side: random stall, checking
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected transaction", rsp, 0);
      end else begin
        rsp_t e;
        e = expected_q.pop_front();
        if (rsp.ok !== e.ok) report("ok", rsp.ok, e.ok);
        if (rsp.found_handle !== e.found_handle)
          report("found_handle", rsp.found_handle, e.found_handle);
        if (rsp.entry_count !== e.entry_count)
          report("entry_count", rsp.entry_count, e.entry_count);
        if (rsp.evicted_count !== e.evicted_count)
          report("evicted_count", rsp.evicted_count, e.evicted_count);
      end
    end
    rsp_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_cmd(req_t r, bit typed, rsp_t want);
    rsp_t p;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    p = predict_lru(r);
    if (typed && p !== want) report("table row vs predictor", p, want);
    expected_q.push_back(p);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cap(int c);
    cfg_valid <= 1'b1;
    cfg_data <= c[CAP_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    t_cap = c;
  endtask

  function automatic req_t mk(cmd_e c, logic [63:0] k, logic [31:0] h, bit u);
    req_t r;
    r.command = c;
    r.key = k;
    r.handle = h;
    r.in_use = u;
    return r;
  endfunction

  function automatic rsp_t rs(bit ok, logic [31:0] fh, int n, int ev);
    rsp_t o;
    o.ok = ok;
    o.found_handle = fh;
    o.entry_count = n[6:0];
    o.evicted_count = ev[6:0];
    return o;
  endfunction

  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    if (keys_seen.size() > 0 && $urandom_range(99) < 75)
      return keys_seen[$urandom_range(keys_seen.size() - 1)];
    k = {$urandom, $urandom};
    if ($urandom_range(9) == 0) k = 0;
    if (keys_seen.size() < 90) keys_seen.push_back(k);
    else keys_seen[$urandom_range(89)] = k;
    return k;
  endfunction

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } row_t;

  initial begin
    row_t rows[$];
    req_t r;
    int caps[6] = '{1, 64, 3, 0, 127, 8};
    t_count = 0;
    t_clock = 0;
    t_cap = 64;
    for (int i = 0; i < NSLOT; i++) t_valid[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk(CMD_GET, 64'h5, 0, 0), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_PUT, 0, 32'h1, 0), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_PUT, 64'h5, 0, 0), 1, rs(0, 0, 0, 0)});
    rows.push_back('{mk(CMD_PUT, '1, '1, 0), 1, rs(1, 0, 1, 0)});
    rows.push_back('{mk(CMD_PEEK, '1, 0, 0), 1, rs(1, '1, 1, 0)});
    rows.push_back('{mk(CMD_PUT, 64'h1, 32'h1, 1), 1, rs(1, 0, 2, 0)});
    rows.push_back('{mk(CMD_PUT, 64'h1, 32'hA5A5, 0), 1, rs(1, 0, 2, 0)});
    rows.push_back('{mk(CMD_GET, 64'h1, 0, 0), 1, rs(1, 32'hA5A5, 2, 0)});
    rows.push_back('{mk(CMD_SETUSE, 64'h1, 0, 1), 1, rs(1, 0, 2, 0)});
    rows.push_back('{mk(CMD_SETUSE, 64'h9, 0, 1), 1, rs(0, 0, 2, 0)});
    rows.push_back('{mk(CMD_ERASE, '1, 0, 0), 1, rs(1, 0, 1, 0)});
    rows.push_back('{mk(CMD_ERASE, '1, 0, 0), 1, rs(0, 0, 1, 0)});
    rows.push_back('{mk(CMD_NOP, '1, '1, 1), 1, rs(0, 0, 1, 0)});
    rows.push_back('{mk(CMD_TRIM, 0, 0, 0), 1, rs(0, 0, 1, 0)});
    rows.push_back('{mk(CMD_CLEAR, 0, 0, 0), 1, rs(0, 0, 0, 0)});
    foreach (rows[i]) send_cmd(rows[i].r, rows[i].typed, rows[i].want);
    drain();

    // capacity 1: unpinned victim, pin-blocked trim after a pinned put, explicit trim
    write_cap(1);
    send_cmd(mk(CMD_PUT, 64'h10, 32'h10, 0), 0, '0);
    send_cmd(mk(CMD_PUT, 64'h11, 32'h11, 0), 1, rs(1, 0, 1, 1));
    send_cmd(mk(CMD_SETUSE, 64'h11, 0, 1), 1, rs(1, 0, 1, 0));
    send_cmd(mk(CMD_PUT, 64'h12, 32'h12, 1), 1, rs(1, 0, 2, 0));
    send_cmd(mk(CMD_SETUSE, 64'h12, 0, 0), 0, '0);
    send_cmd(mk(CMD_TRIM, 0, 0, 0), 1, rs(0, 0, 1, 1));
    send_cmd(mk(CMD_CLEAR, 0, 0, 0), 0, '0);
    drain();
    // table full of pinned entries at capacity 64
    write_cap(64);
    for (int i = 1; i <= NSLOT; i++)
      send_cmd(mk(CMD_PUT, 64'h100 + i, i, 1), 0, '0);
    send_cmd(mk(CMD_PUT, 64'h200, 32'h7, 0), 1, rs(1, 0, 64, 1));
    send_cmd(mk(CMD_PUT, 64'h201, 32'h7, 1), 1, rs(0, 0, 64, 0));
    send_cmd(mk(CMD_SETUSE, 64'h120, 0, 0), 0, '0);
    send_cmd(mk(CMD_PUT, 64'h202, 32'h8, 1), 1, rs(1, 0, 64, 1));
    send_cmd(mk(CMD_CLEAR, 0, 0, 0), 0, '0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_cap(caps[ph % 6]);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 78; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 78; end
        default: begin send_idle = 9; recv_stall = 9; end
      endcase
      for (int n = 0; n < NRAND / 8; n++) begin
        int w;
        w = $urandom_range(99);
        r.key = pick_key();
        r.handle = ($urandom_range(15) == 0) ? 32'h0 : $urandom;
        r.in_use = ($urandom_range(3) == 0);
        if (w < 40) r.command = CMD_PUT;
        else if (w < 58) r.command = CMD_GET;
        else if (w < 70) r.command = CMD_PEEK;
        else if (w < 80) r.command = CMD_ERASE;
        else if (w < 90) r.command = CMD_SETUSE;
        else if (w < 95) r.command = CMD_TRIM;
        else if (w < 97) r.command = CMD_CLEAR;
        else r.command = CMD_NOP;
        send_cmd(r, 0, '0);
      end
      send_cmd(mk(CMD_TRIM, 0, 0, 0), 0, '0);
      drain();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
hdl/lrt_pkg.sv
hdl/lrt_ctrl.sv
hdl/lrt_dpath.sv
hdl/lru_table_with_pinning.sv
dv/tb_top.sv
